### rtl/core/mhd_pkg.sv
// Shared types, widths and helpers for the motion history differentiator.
// No dependencies; every other file in rtl/core refers to this package by scope.

package mhd_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int SUM_W             = 40;
    localparam int LOOK_W            = 4;
    localparam int WIN_W             = 5;
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

    typedef enum logic {
        REQ_POSITION = 1'b0,
        REQ_VELOCITY = 1'b1
    } req_type_t;

    // Control that the top level hands to each history ring.
    typedef struct packed {
        logic push;
        logic clear;
    } hist_ctl_t;

    // Clamp a one-bit-grown signed value to the signed sample range.
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SAMPLE_W:0] v);
        logic [SAMPLE_W-1:0] res;
        if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
            res = {v[SAMPLE_W], {(SAMPLE_W-1){~v[SAMPLE_W]}}};
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/mhd_kinematics.sv
// Forms the new position, velocity and acceleration entries from one sample.
// Depends on mhd_pkg for widths, the request type and the saturating clamp.

module mhd_kinematics (
    input  mhd_pkg::req_type_t               req_type,
    input  logic [mhd_pkg::SAMPLE_W-1:0]     sample,
    input  logic [mhd_pkg::SAMPLE_W-1:0]     prev_pos,
    input  logic [mhd_pkg::SAMPLE_W-1:0]     prev_vel,
    output logic [mhd_pkg::SAMPLE_W-1:0]     new_pos,
    output logic [mhd_pkg::SAMPLE_W-1:0]     new_vel,
    output logic [mhd_pkg::SAMPLE_W-1:0]     new_acc
);

    localparam int W = mhd_pkg::SAMPLE_W;

    logic [W:0]   smp_x, ppos_x, pvel_x;
    logic [W-1:0] vel_from_pos, acc_from_pos, pos_from_vel, acc_from_vel;

    assign smp_x  = {sample[W-1], sample};
    assign ppos_x = {prev_pos[W-1], prev_pos};
    assign pvel_x = {prev_vel[W-1], prev_vel};

    always_comb begin
        // Position sample: velocity is the previous position minus the sample, and
        // acceleration is the previous velocity minus the freshly clamped velocity.
        vel_from_pos = mhd_pkg::sat_sample(ppos_x - smp_x);
        acc_from_pos = mhd_pkg::sat_sample(pvel_x - {vel_from_pos[W-1], vel_from_pos});
        // Velocity sample: position integrates, acceleration differences.
        pos_from_vel = mhd_pkg::sat_sample(ppos_x + smp_x);
        acc_from_vel = mhd_pkg::sat_sample(pvel_x - smp_x);

        case (req_type)
            mhd_pkg::REQ_POSITION: begin
                new_pos = sample;
                new_vel = vel_from_pos;
                new_acc = acc_from_pos;
            end
            mhd_pkg::REQ_VELOCITY: begin
                new_pos = pos_from_vel;
                new_vel = sample;
                new_acc = acc_from_vel;
            end
            default: begin
                new_pos = sample;
                new_vel = vel_from_pos;
                new_acc = acc_from_pos;
            end
        endcase
    end

endmodule

### rtl/core/mhd_history.sv
// One history ring kept as a shift line with a running window sum.
// Depends on mhd_pkg for widths and the ring control struct.

module mhd_history #(
    parameter  int DEPTH = mhd_pkg::HISTORY_DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mhd_pkg::hist_ctl_t            ctl,
    input  logic [mhd_pkg::SAMPLE_W-1:0]  push_data,
    input  logic [IDX_W-1:0]              exit_tap,
    input  logic [IDX_W-1:0]              read_tap,
    output logic [mhd_pkg::SAMPLE_W-1:0]  newest,
    output logic [mhd_pkg::SAMPLE_W-1:0]  read_data,
    output logic [mhd_pkg::SUM_W-1:0]     total_next
);

    localparam int W  = mhd_pkg::SAMPLE_W;
    localparam int SW = mhd_pkg::SUM_W;

    logic [W-1:0]  taps_reg  [DEPTH];
    logic [W-1:0]  taps_next [DEPTH];
    logic [SW-1:0] total_reg;
    logic [W-1:0]  leaving;

    // Tap 0 holds the newest entry; the view after a push shifts by one.
    always_comb begin
        taps_next[0] = push_data;
        for (int i = 1; i < DEPTH; i++) begin
            taps_next[i] = taps_reg[i-1];
        end
    end

    // The entry that drops out of the window is the oldest one inside it
    // before the push.
    assign leaving    = taps_reg[exit_tap];
    assign total_next = total_reg - {{(SW-W){leaving[W-1]}}, leaving}
                                  + {{(SW-W){push_data[W-1]}}, push_data};

    assign newest    = taps_reg[0];
    assign read_data = taps_next[read_tap];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int i = 0; i < DEPTH; i++) begin
                taps_reg[i] <= '0;
            end
            total_reg <= '0;
        end else if (ctl.push) begin
            for (int i = 0; i < DEPTH; i++) begin
                taps_reg[i] <= taps_next[i];
            end
            total_reg <= total_next;
        end
    end

endmodule

### rtl/core/motion_history_differentiator.sv
// Channel  Direction  Word contents (low bit first)                       Handshake
// s_       in         tdata: sample[31:0], look_back[35:32], zero pad      tvalid/tready
//                     tuser: req_type
// m_       out        tdata: pos_at, vel_at, acc_at, pos_sum, vel_sum,     tvalid/tready
//                            acc_sum (216 bits); tuser: index_ok
// cfg_     in         cfg_wdata: window_len, written when cfg_we is high   none
//
// One word per cycle is sustained while m_tready stays high; a word taken on s_ passes
// through the input register and then the result register before it is presented on m_.
// The ring update, the difference chain and the window sums all settle combinationally
// between those two registers.
// Reset (aresetn low, synchronous) clears the rings and sums and sets the window to 16.
// When m_tready is low a full result register holds, and s_tready drops once the input
// register is also full.  A window write clears all history in the same cycle.

module motion_history_differentiator #(
    parameter int HISTORY_DEPTH = mhd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [mhd_pkg::WIN_W-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,   // sample[31:0], look_back[35:32], pad
    input  logic                       s_tuser,   // req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pos_at[31:0], vel_at[63:32], acc_at[95:64],
    // pos_sum[135:96], vel_sum[175:136], acc_sum[215:176]
    output logic [215:0]               m_tdata,
    output logic                       m_tuser    // index_ok
);

    localparam int W     = mhd_pkg::SAMPLE_W;
    localparam int SW    = mhd_pkg::SUM_W;
    localparam int LW    = mhd_pkg::LOOK_W;
    localparam int WW    = mhd_pkg::WIN_W;
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic [WW-1:0]      win_reg;
    logic [WW-1:0]      eff_win;
    logic               in_valid_reg, in_valid_next;
    mhd_pkg::req_type_t in_type_reg;
    logic [W-1:0]       in_sample_reg;
    logic [LW-1:0]      in_look_reg;
    logic               out_valid_reg, out_valid_next;
    logic [215:0]       out_data_reg, out_data_next;
    logic               out_ok_reg, out_ok_next;

    logic               out_load, advance, take;
    logic               index_ok;
    logic [IDX_W-1:0]   exit_tap, read_tap;
    mhd_pkg::hist_ctl_t ctl;

    logic [W-1:0]  pos_newest, vel_newest, acc_newest;
    logic [W-1:0]  new_pos, new_vel, new_acc;
    logic [W-1:0]  pos_rd, vel_rd, acc_rd;
    logic [SW-1:0] pos_tot, vel_tot, acc_tot;

    // Flow control: the result register frees up when it is empty or being taken.
    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign take     = s_tvalid && s_tready;

    assign ctl.push  = advance;
    assign ctl.clear = cfg_we;

    always_comb begin
        if (win_reg == '0) begin
            eff_win = WW'(1);
        end else if (32'(win_reg) > 32'(HISTORY_DEPTH)) begin
            eff_win = WW'(HISTORY_DEPTH);
        end else begin
            eff_win = win_reg;
        end
    end

    assign exit_tap = IDX_W'(eff_win - WW'(1));
    assign read_tap = IDX_W'(in_look_reg);
    assign index_ok = {1'b0, in_look_reg} < eff_win;

    mhd_kinematics u_kin (
        .req_type (in_type_reg),
        .sample   (in_sample_reg),
        .prev_pos (pos_newest),
        .prev_vel (vel_newest),
        .new_pos  (new_pos),
        .new_vel  (new_vel),
        .new_acc  (new_acc)
    );

    mhd_history #(.DEPTH(HISTORY_DEPTH)) u_pos_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .push_data  (new_pos),
        .exit_tap   (exit_tap),
        .read_tap   (read_tap),
        .newest     (pos_newest),
        .read_data  (pos_rd),
        .total_next (pos_tot)
    );

    mhd_history #(.DEPTH(HISTORY_DEPTH)) u_vel_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .push_data  (new_vel),
        .exit_tap   (exit_tap),
        .read_tap   (read_tap),
        .newest     (vel_newest),
        .read_data  (vel_rd),
        .total_next (vel_tot)
    );

    mhd_history #(.DEPTH(HISTORY_DEPTH)) u_acc_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .push_data  (new_acc),
        .exit_tap   (exit_tap),
        .read_tap   (read_tap),
        .newest     (acc_newest),
        .read_data  (acc_rd),
        .total_next (acc_tot)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (take) begin
            in_valid_next = 1'b1;
        end
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
        if (advance) begin
            // Entries outside the window report as zero; the sums are unaffected.
            out_data_next = {acc_tot, vel_tot, pos_tot,
                             index_ok ? acc_rd : '0,
                             index_ok ? vel_rd : '0,
                             index_ok ? pos_rd : '0};
            out_ok_next   = index_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= mhd_pkg::WINDOW_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                win_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_type_reg   <= mhd_pkg::req_type_t'(s_tuser);
            in_sample_reg <= s_tdata[W-1:0];
            in_look_reg   <= s_tdata[W+LW-1:W];
        end
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    // A window write restarts the history from zero.
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (pos_newest == '0 && vel_newest == '0 && acc_newest == '0))
        else $error("history not cleared after window write");

    // A word that leaves the input register shows up as a result next cycle.
    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced word missing from result register");

    // Out-of-window look-backs report zero entries.
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[95:0] == '0))
        else $error("out-of-window entries not zero");

endmodule
